// ===== rtl/rle_pkg.sv =====
// Shared types and constants for the run-length RGB to RGBA5551 expander.
package rle_pkg;

  localparam int HEADER_BYTES_DEF = 10;
  localparam int LANES_DEF        = 4;

  localparam int BYTE_W   = 8;
  localparam int PIXEL_W  = 16;
  localparam int COPIES_W = 3;
  localparam int COUNT_W  = 8;
  localparam int TOTAL_W  = 33;

  localparam int OUT_DATA_W = ((PIXEL_W + COPIES_W + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int HDR_WIDTH_HI  = 0;
  localparam int HDR_WIDTH_LO  = 1;
  localparam int HDR_HEIGHT_HI = 2;
  localparam int HDR_HEIGHT_LO = 3;

  localparam int REC_COUNT = 0;
  localparam int REC_RED   = 1;
  localparam int REC_GREEN = 2;
  localparam int REC_BLUE  = 3;

  typedef struct packed {
    logic [PIXEL_W-1:0] pix;
    logic [COUNT_W-1:0] count;
    logic               done;
  } rle_cmd_t;

endpackage

// ===== rtl/rle_parse.sv =====
// Front end: parses the header and run records and queues one command per run.
module rle_parse #(
  parameter int HEADER_BYTES = rle_pkg::HEADER_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [rle_pkg::BYTE_W-1:0] in_byte,
  input  logic                      q_full,
  output logic                      q_push,
  output rle_pkg::rle_cmd_t         q_cmd
);
  import rle_pkg::*;

  localparam int PH_W = $clog2(HEADER_BYTES);

  logic                in_header_r, in_header_nxt;
  logic [PH_W-1:0]     ph_r, ph_nxt;
  logic [15:0]         width_r, width_nxt;
  logic [TOTAL_W-1:0]  left_r, left_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0]   red_r, red_nxt;
  logic [BYTE_W-1:0]   green_r, green_nxt;
  logic                accept;
  logic [TOTAL_W-1:0]  left_sub;
  logic                exhausted;
  logic [31:0]         area;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign left_sub  = left_r - TOTAL_W'(count_r);
  assign exhausted = (left_sub == '0) || left_sub[TOTAL_W-1];
  assign area      = width_r * {left_r[7:0], in_byte};

  assign q_cmd.pix   = {in_byte[7:3], green_r[7:3], red_r[7:3], 1'b1};
  assign q_cmd.count = count_r;
  assign q_cmd.done  = exhausted;
  assign q_push      = accept && !in_header_r && (ph_r == PH_W'(REC_BLUE));

  always_comb begin
    in_header_nxt = in_header_r;
    ph_nxt        = ph_r;
    width_nxt     = width_r;
    left_nxt      = left_r;
    count_nxt     = count_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    if (accept) begin
      if (in_header_r) begin
        if (ph_r == PH_W'(HDR_WIDTH_HI)) begin
          width_nxt = {in_byte, 8'h00};
        end else if (ph_r == PH_W'(HDR_WIDTH_LO)) begin
          width_nxt = {width_r[15:8], in_byte};
        end else if (ph_r == PH_W'(HDR_HEIGHT_HI)) begin
          left_nxt = TOTAL_W'(in_byte);
        end else if (ph_r == PH_W'(HDR_HEIGHT_LO)) begin
          left_nxt = {1'b0, area};
        end
        if (ph_r == PH_W'(HEADER_BYTES - 1)) begin
          ph_nxt        = '0;
          in_header_nxt = 1'b0;
        end else begin
          ph_nxt = ph_r + 1'b1;
        end
      end else begin
        if (ph_r == PH_W'(REC_COUNT)) begin
          count_nxt = in_byte;
          ph_nxt    = PH_W'(REC_RED);
        end else if (ph_r == PH_W'(REC_RED)) begin
          red_nxt = in_byte;
          ph_nxt  = PH_W'(REC_GREEN);
        end else if (ph_r == PH_W'(REC_GREEN)) begin
          green_nxt = in_byte;
          ph_nxt    = PH_W'(REC_BLUE);
        end else begin
          left_nxt      = left_sub;
          ph_nxt        = PH_W'(REC_COUNT);
          in_header_nxt = exhausted;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_header_r <= 1'b1;
      ph_r        <= '0;
      width_r     <= '0;
      left_r      <= '0;
      count_r     <= '0;
      red_r       <= '0;
      green_r     <= '0;
    end else begin
      in_header_r <= in_header_nxt;
      ph_r        <= ph_nxt;
      width_r     <= width_nxt;
      left_r      <= left_nxt;
      count_r     <= count_nxt;
      red_r       <= red_nxt;
      green_r     <= green_nxt;
    end
  end

endmodule

// ===== rtl/rle_fifo.sv =====
// Short command queue between the record parser and the run emitter.
module rle_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rle_pkg::rle_cmd_t push_cmd,
  input  logic              pop,
  output rle_pkg::rle_cmd_t head_cmd,
  output logic              empty,
  output logic              full
);
  import rle_pkg::*;

  rle_cmd_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wp_r, wp_nxt;
  logic [QPTR_W-1:0]   rp_r, rp_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_cmd = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/rle_emit.sv =====
// Back end: splits each queued run into groups of copies behind an output register.
module rle_emit #(
  parameter int LANES = rle_pkg::LANES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rle_pkg::rle_cmd_t             head_cmd,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rle_pkg::PIXEL_W-1:0]   out_pixel,
  output logic [rle_pkg::COPIES_W-1:0]  out_copies,
  output logic                          out_run_last,
  output logic                          out_image_done
);
  import rle_pkg::*;

  localparam int LN_W = $clog2(LANES + 1);

  logic                 busy_r, busy_nxt;
  logic [COUNT_W-1:0]   rem_r, rem_nxt;
  logic [PIXEL_W-1:0]   pix_r, pix_nxt;
  logic                 done_r, done_nxt;
  logic                 valid_r, valid_nxt;
  logic [PIXEL_W-1:0]   opix_r, opix_nxt;
  logic [COPIES_W-1:0]  ocop_r, ocop_nxt;
  logic                 olast_r, olast_nxt;
  logic                 odone_r, odone_nxt;
  logic                 adv;
  logic                 have;
  logic [COUNT_W-1:0]   rem_src;
  logic [PIXEL_W-1:0]   pix_src;
  logic                 done_src;
  logic [LN_W-1:0]      grp;
  logic [COUNT_W-1:0]   rem_after;

  assign adv      = !valid_r || out_tready;
  assign have     = busy_r || !q_empty;
  assign rem_src  = busy_r ? rem_r :
                    ((head_cmd.count == '0) ? COUNT_W'(1) : head_cmd.count);
  assign pix_src  = busy_r ? pix_r : head_cmd.pix;
  assign done_src = busy_r ? done_r : head_cmd.done;
  assign grp      = (rem_src > COUNT_W'(LANES)) ? LN_W'(LANES) : LN_W'(rem_src);
  assign rem_after = rem_src - COUNT_W'(grp);
  assign q_pop    = adv && !busy_r && !q_empty;

  always_comb begin
    busy_nxt  = busy_r;
    rem_nxt   = rem_r;
    pix_nxt   = pix_r;
    done_nxt  = done_r;
    valid_nxt = valid_r;
    opix_nxt  = opix_r;
    ocop_nxt  = ocop_r;
    olast_nxt = olast_r;
    odone_nxt = odone_r;
    if (adv) begin
      valid_nxt = have;
      if (have) begin
        opix_nxt  = pix_src;
        ocop_nxt  = COPIES_W'(grp);
        olast_nxt = (rem_after == '0);
        odone_nxt = (rem_after == '0) && done_src;
        busy_nxt  = (rem_after != '0);
        rem_nxt   = rem_after;
        pix_nxt   = pix_src;
        done_nxt  = done_src;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    pix_r   <= pix_nxt;
    done_r  <= done_nxt;
    opix_r  <= opix_nxt;
    ocop_r  <= ocop_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign out_tvalid     = valid_r;
  assign out_pixel      = opix_r;
  assign out_copies     = ocop_r;
  assign out_run_last   = olast_r;
  assign out_image_done = odone_r;

endmodule

// ===== rtl/rle_rgb_to_rgba5551_expander.sv =====
// Top level of the run-length RGB to RGBA5551 expander.
// Throughput: one stream byte per cycle while the run queue has room; a run of N
// copies leaves as ceil(N/LANES) transfers, one per cycle from the emitter while
// out_tready is high. With the emitter idle, a run's blue byte is written into the
// run queue, then the emitter loads its first group into the output register and
// raises out_tvalid. A four-entry run queue decouples the byte parser from the
// emitter; in_tready drops only while that queue is full. Synchronous active-low
// reset empties the queue and output register and waits for a header byte.
module rle_rgb_to_rgba5551_expander #(
  parameter int HEADER_BYTES = rle_pkg::HEADER_BYTES_DEF,
  parameter int LANES        = rle_pkg::LANES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rle_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] stream_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rle_pkg::OUT_DATA_W-1:0]    out_tdata,  // [15:0] pixel, [18:16] copies
  output logic                              out_tlast,  // run_last
  output logic                              out_tuser   // image_done
);
  import rle_pkg::*;

  rle_cmd_t             push_cmd;
  rle_cmd_t             head_cmd;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_empty;
  logic                 q_full;
  logic [PIXEL_W-1:0]   pixel;
  logic [COPIES_W-1:0]  copies;

  rle_parse #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_byte  (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  rle_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(push_cmd),
    .pop     (q_pop),
    .head_cmd(head_cmd),
    .empty   (q_empty),
    .full    (q_full)
  );

  rle_emit #(
    .LANES(LANES)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_cmd      (head_cmd),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_pixel     (pixel),
    .out_copies    (copies),
    .out_run_last  (out_tlast),
    .out_image_done(out_tuser)
  );

  assign out_tdata = {{(OUT_DATA_W - PIXEL_W - COPIES_W){1'b0}}, copies, pixel};

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("run queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("run queue read while empty");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("image end flagged on a transfer that does not end its run");

  a_full_groups: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (copies == COPIES_W'(LANES)))
    else $error("group before the end of a run is not full");

endmodule
